>>> hdl/b64e_pkg.sv
`timescale 1ns / 1ps
// Package for the Base64 stream encoder: job type passed from the front end
// to the character sequencer, and the 6-bit to ASCII symbol mapping.
package b64e_pkg;

    localparam int unsigned JOB_CHARS = 4;
    localparam logic [7:0]  PAD_CHAR  = 8'h3D;   // '='

    // One classified input byte: up to four ready-made characters.
    typedef struct packed {
        logic [JOB_CHARS-1:0][7:0] chars;
        logic [1:0]                last_idx;   // index of the final char in this job
        logic                      eot;        // final char ends the message
    } t_job;

    typedef logic [5:0] t_sextet;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sym(input t_sextet six);
        logic [7:0] ch;
        ch = 8'h2F;
        case (six) inside
            [6'd0:6'd25]:  ch = 8'h41 + {2'b00, six};
            [6'd26:6'd51]: ch = 8'h61 + {2'b00, six} - 8'd26;
            [6'd52:6'd61]: ch = 8'h30 + {2'b00, six} - 8'd52;
            6'd62:         ch = 8'h2B;
            default:       ch = 8'h2F;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/base64_stream_encoder_unit.sv
`timescale 1ns / 1ps
// Base64 stream encoder (standard alphabet, '=' padding). One raw byte per
// push transaction, one ASCII character per pop transaction; the final
// character of each message carries o_end_of_text. A byte is classified in
// the cycle it is pushed and stored as a job of one to four characters in a
// QUEUE_DEPTH-entry job queue; the sequencer then moves one character per
// cycle, while the output register is empty or being popped, into that
// register, so a byte's first character passes through a queue entry and
// then the output register. Bytes can be pushed on consecutive cycles until
// the queue fills. The output port, one character per pop, sets the sustained
// rate: four characters per three bytes, up to four for a message's last byte.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
module base64_stream_encoder_unit
    import b64e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_end_of_text
);

    t_job wr_job;
    t_job head_job;
    logic wr;
    logic rd;
    logic head_valid;

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_wr        (wr),
        .o_job       (wr_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_job   (wr_job),
        .i_rd    (rd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_job)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (head_valid),
        .i_head        (head_job),
        .o_rd          (rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

endmodule

>>> hdl/b64e_front.sv
`timescale 1ns / 1ps
// Front end: accepts raw bytes, tracks group position and carried bits, and
// turns each byte into a character job. Depends on b64e_pkg.
module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_wr,
    output t_job       o_job
);

    logic [1:0] r_pos, n_pos;
    logic [3:0] r_carry, n_carry;

    assign o_wr = i_push && !i_full;

    always_comb begin
        o_job.chars    = {JOB_CHARS{PAD_CHAR}};
        o_job.eot      = i_last_byte;
        o_job.last_idx = 2'd0;
        n_pos          = r_pos;
        n_carry        = r_carry;
        case (r_pos)
            2'd1: begin
                o_job.chars[0] = sym({r_carry[1:0], i_data_byte[7:4]});
                n_carry        = i_data_byte[3:0];
                n_pos          = 2'd2;
                if (i_last_byte) begin
                    o_job.chars[1] = sym({i_data_byte[3:0], 2'b00});
                    o_job.last_idx = 2'd2;
                end
            end
            2'd2: begin
                o_job.chars[0] = sym({r_carry, i_data_byte[7:6]});
                o_job.chars[1] = sym(i_data_byte[5:0]);
                o_job.last_idx = 2'd1;
                n_carry        = 4'd0;
                n_pos          = 2'd0;
            end
            default: begin
                o_job.chars[0] = sym(i_data_byte[7:2]);
                n_carry        = {2'b00, i_data_byte[1:0]};
                n_pos          = 2'd1;
                if (i_last_byte) begin
                    o_job.chars[1] = sym({i_data_byte[1:0], 4'b0000});
                    o_job.last_idx = 2'd3;
                end
            end
        endcase
        // message ends: next byte opens a fresh group
        if (i_last_byte) begin
            n_pos   = 2'd0;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_carry <= 4'd0;
        end else if (o_wr) begin
            r_pos   <= n_pos;
            r_carry <= n_carry;
        end
    end

endmodule

>>> hdl/b64e_queue.sv
`timescale 1ns / 1ps
// Job queue between the front end and the character sequencer.
// Small register file with read/write pointers. Depends on b64e_pkg.
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_job,
    input  logic i_rd,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full && !i_rd))
        else $error("job written into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && !o_valid))
        else $error("job read from empty queue");

endmodule

>>> hdl/b64e_back.sv
`timescale 1ns / 1ps
// Character sequencer: walks the head job one character per cycle into the
// output register while it is free or being popped. Depends on b64e_pkg.
module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_head,
    output logic       o_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_char,
    output logic       o_end_of_text
);

    logic [1:0] r_idx, n_idx;
    logic       r_ov, n_ov;
    logic [7:0] r_char;
    logic       r_eot;
    logic       adv;
    logic       job_done;

    // output slot free or being drained this cycle
    assign adv      = i_valid && (!r_ov || i_pop);
    assign job_done = (r_idx == i_head.last_idx);
    assign o_rd     = adv && job_done;

    always_comb begin
        n_idx = r_idx;
        n_ov  = r_ov && !i_pop;
        if (adv) begin
            n_ov  = 1'b1;
            n_idx = job_done ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_ov  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_char <= i_head.chars[r_idx];
            r_eot  <= i_head.eot && job_done;
        end
    end

    assign o_empty       = !r_ov;
    assign o_out_char    = r_char;
    assign o_end_of_text = r_eot;

    // a partly emitted job must stay at the queue head
    a_mid_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> i_valid)
        else $error("job left the queue before all characters were sent");
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_idx <= i_head.last_idx))
        else $error("character index beyond end of job");
    a_rd_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd |=> (r_idx == 2'd0))
        else $error("index not cleared after job completed");

endmodule
